/* hw/rtl/swm_pkg.sv */
`default_nettype none

package swm_pkg;

  // Window storage and field widths
  localparam int unsigned MAX_WINDOW   = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned WINDOW_RESET = 64;

  localparam int unsigned IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned AGE_W    = IDX_W;
  localparam int unsigned CNT_W    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PFX_LVLS = $clog2(MAX_WINDOW);

  // Result queue
  localparam int unsigned OUTQ_DEPTH = 3;
  localparam int unsigned OQ_IDX_W   = $clog2(OUTQ_DEPTH);
  localparam int unsigned OQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]         cfg_t;
  typedef logic [AGE_W-1:0]         age_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [OQ_CNT_W-1:0]      oq_cnt_t;

  // One sorted entry: value and number of items since it arrived
  typedef struct packed {
    sample_t val;
    age_t    age;
  } entry_t;

  // Broadcast to every cell
  typedef struct packed {
    sample_t sample;
    logic    remove;
    age_t    tgt_age;
    logic    upd;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/swm_if.sv */
`default_nettype none

interface swm_sample_if;
  import swm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swm_median_if;
  import swm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t median;
  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

interface swm_cfg_if;
  import swm_pkg::*;
  logic valid;
  logic ready;
  cfg_t window_size;
  modport source (output valid, output window_size, input ready);
  modport sink (input valid, input window_size, output ready);
endinterface

`default_nettype wire

/* hw/rtl/swm_cell.sv */
`default_nettype none

module swm_cell (
  input  logic               clk_i,
  input  swm_pkg::cell_ctl_t ctl_i,
  input  logic               valid_i,
  input  logic               validn_i,
  input  logic               gr_i,
  input  swm_pkg::entry_t    right_i,
  input  logic               right_le_i,
  input  swm_pkg::entry_t    left_a_i,
  input  logic               left_ins_i,
  output swm_pkg::entry_t    own_o,
  output swm_pkg::entry_t    a_o,
  output logic               le_o,
  output logic               ins_o,
  output logic               match_o
);
  import swm_pkg::*;

  entry_t ent_q, ent_d;
  entry_t a_ent;
  logic   a_le;

  assign own_o = ent_q;

  // Flag the oldest sample and compare the new sample against this entry
  assign match_o = valid_i && ctl_i.remove && (ent_q.age == ctl_i.tgt_age);
  assign le_o    = !($signed(ctl_i.sample) < $signed(ent_q.val));

  // Close the gap left by the removed entry
  assign a_ent = gr_i ? right_i : ent_q;
  assign a_le  = gr_i ? right_le_i : le_o;
  assign a_o   = a_ent;
  assign ins_o = validn_i && a_le;

  // Keep, take the new sample, or shift up from the left neighbor
  always_comb begin
    if (ins_o) begin
      ent_d.val = a_ent.val;
      ent_d.age = AGE_W'(a_ent.age + 1'b1);
    end else if (left_ins_i) begin
      ent_d.val = ctl_i.sample;
      ent_d.age = '0;
    end else begin
      ent_d.val = left_a_i.val;
      ent_d.age = AGE_W'(left_a_i.age + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      ent_q <= ent_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/swm_prefix.sv */
`default_nettype none

module swm_prefix (
  input  logic [swm_pkg::MAX_WINDOW-1:0] match_i,
  output logic [swm_pkg::MAX_WINDOW-1:0] gr_o
);
  import swm_pkg::*;

  logic [MAX_WINDOW-1:0] lvl [PFX_LVLS+1];

  // Parallel prefix OR: bit i is set when any entry at or below i matches
  always_comb begin
    lvl[0] = match_i;
    for (int l = 0; l < PFX_LVLS; l++) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        if (i >= (1 << l)) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  assign gr_o = lvl[PFX_LVLS];

endmodule

`default_nettype wire

/* hw/rtl/swm_outq.sv */
`default_nettype none

module swm_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  swm_pkg::sample_t    push_data_i,
  output swm_pkg::oq_cnt_t    level_o,
  swm_median_if.source        med_o
);
  import swm_pkg::*;

  sample_t                data_q [OUTQ_DEPTH];
  sample_t                data_d [OUTQ_DEPTH];
  oq_cnt_t                occ_q, occ_d;
  logic                   pop;
  logic [OQ_IDX_W-1:0]    widx;

  assign pop        = med_o.valid && med_o.ready;
  assign med_o.valid = (occ_q != '0);
  assign med_o.median = data_q[0];
  assign level_o    = occ_q;

  assign widx  = OQ_IDX_W'(occ_q - oq_cnt_t'(pop));
  assign occ_d = oq_cnt_t'(occ_q + oq_cnt_t'(push_i) - oq_cnt_t'(pop));

  // Track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Advance on a transfer, append behind the last held result
  always_comb begin
    data_d = data_q;
    if (pop) begin
      for (int k = 0; k < OUTQ_DEPTH - 1; k++) begin
        data_d[k] = data_q[k+1];
      end
    end
    if (push_i) begin
      data_d[widx] = push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/sliding_window_median.sv */
`default_nettype none
// Channel   Modport  Payload               Moves
// samp_i    sink     sample[31:0] signed   one sample per transfer
// med_o     source   median[31:0] signed   one lower median per transfer
// cfg_i     sink     window_size[6:0]      register write, restarts the fill
//
// One sample is taken per cycle while samp_i.ready is high; the row of 64 sorting
// cells removes the oldest entry and inserts the new one in the same cycle.
// A median is registered in the cell row on its sample's transfer, then captured
// into a three-entry result queue that drives med_o.
// samp_i.ready drops only while the result queue and the pending capture hold
// three results. cfg_i.ready is always high. No clearing pass after reset.

module sliding_window_median (
  input  logic          clk_i,
  input  logic          rst_ni,
  swm_sample_if.sink    samp_i,
  swm_median_if.source  med_o,
  swm_cfg_if.sink       cfg_i
);
  import swm_pkg::*;

  cnt_t    fill_q, fill_d;
  cnt_t    weff_q, weff_d;
  idx_t    mid_q, mid_d;
  logic    pend_q;
  oq_cnt_t level;

  logic      in_acc, cfg_acc, remove, emit;
  cnt_t      fill_after;
  cell_ctl_t ctl;
  sample_t   med_val;

  entry_t                ent      [MAX_WINDOW];
  entry_t                a_ent    [MAX_WINDOW];
  entry_t                right_e  [MAX_WINDOW];
  entry_t                left_e   [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] le, ins, match, gr, valid, validn, right_le, left_ins;

  assign in_acc  = samp_i.valid && samp_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign samp_i.ready = (int'(level) + int'(pend_q)) < OUTQ_DEPTH;

  // Window bookkeeping
  assign remove     = (fill_q == weff_q);
  assign fill_after = remove ? fill_q : cnt_t'(fill_q + 1'b1);
  assign emit       = (fill_after == weff_q);

  // Clamp the written size to 1..MAX_WINDOW
  always_comb begin
    if (cfg_i.window_size == '0) begin
      weff_d = cnt_t'(1);
    end else if (int'(cfg_i.window_size) > MAX_WINDOW) begin
      weff_d = cnt_t'(MAX_WINDOW);
    end else begin
      weff_d = cnt_t'(cfg_i.window_size);
    end
    mid_d = IDX_W'((weff_d - 1'b1) >> 1);
  end

  always_comb begin
    fill_d = fill_q;
    if (cfg_acc) begin
      fill_d = '0;
    end else if (in_acc) begin
      fill_d = fill_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      weff_q <= cnt_t'(WINDOW_RESET);
      mid_q  <= IDX_W'((WINDOW_RESET - 1) / 2);
      pend_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      pend_q <= in_acc && emit;
      if (cfg_acc) begin
        weff_q <= weff_d;
        mid_q  <= mid_d;
      end
    end
  end

  // Broadcast to the cell row
  assign ctl.sample  = samp_i.sample;
  assign ctl.remove  = remove;
  assign ctl.tgt_age = AGE_W'(weff_q - 1'b1);
  assign ctl.upd     = in_acc;

  swm_prefix u_prefix (
    .match_i (match),
    .gr_o    (gr)
  );

  // Row of sorting cells, each linked to both neighbors
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    assign valid[i]  = cnt_t'(i) < fill_q;
    assign validn[i] = cnt_t'(i) < cnt_t'(fill_q - cnt_t'(remove));

    if (i == MAX_WINDOW - 1) begin : g_last
      assign right_e[i]  = '0;
      assign right_le[i] = 1'b0;
    end else begin : g_mid
      assign right_e[i]  = ent[i+1];
      assign right_le[i] = le[i+1];
    end

    if (i == 0) begin : g_first
      assign left_e[i]   = '0;
      assign left_ins[i] = 1'b1;
    end else begin : g_rest
      assign left_e[i]   = a_ent[i-1];
      assign left_ins[i] = ins[i-1];
    end

    swm_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .valid_i    (valid[i]),
      .validn_i   (validn[i]),
      .gr_i       (gr[i]),
      .right_i    (right_e[i]),
      .right_le_i (right_le[i]),
      .left_a_i   (left_e[i]),
      .left_ins_i (left_ins[i]),
      .own_o      (ent[i]),
      .a_o        (a_ent[i]),
      .le_o       (le[i]),
      .ins_o      (ins[i]),
      .match_o    (match[i])
    );
  end

  // Pick the middle cell in the cycle after the update
  always_comb begin
    med_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (IDX_W'(i) == mid_q) begin
        med_val = med_val | ent[i].val;
      end
    end
  end

  swm_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pend_q),
    .push_data_i (med_val),
    .level_o     (level),
    .med_o       (med_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/swm_checker.sv */
`default_nettype none

module swm_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input swm_pkg::sample_t median_i
);
  import swm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // Hold a result until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("median valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(median_i))
    else $error("stalled median changed");

  // A result appears only behind a sample transfer, via the pending capture and the queue
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 2))
    else $error("median appeared without a sample");

  // Back-pressure only while results wait downstream
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (samp_i.valid),
  .in_ready_i  (samp_i.ready),
  .out_valid_i (med_o.valid),
  .out_ready_i (med_o.ready),
  .median_i    (med_o.median)
);

`default_nettype wire

/* tb/swm_median_check.sv */
`timescale 1ns / 100ps

module swm_median_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  swm_sample_if       samp_i,
  swm_median_if       med_i,
  swm_cfg_if          cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned backlog_o
);
  import swm_pkg::*;

  // Shadow copy of the window: register, arrival line and sorted store
  cfg_t        window_reg;
  sample_t     arrivals [MAX_WINDOW];
  sample_t     ranked [MAX_WINDOW];
  int unsigned fill;
  sample_t     expected_medians [$];

  // Push one sample through the window; returns 1 when a median is due
  function automatic bit advance_window(input sample_t s, output sample_t med);
    int unsigned span;
    int unsigned pos;
    int          i;
    span = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg;
    if (fill > span) fill = span;

    // Drop the oldest sample; on ties the first equal sorted entry goes
    if (fill == span) begin
      pos = fill - 1;
      for (i = 0; i < fill; i++) begin
        if (ranked[i] == arrivals[span-1]) begin
          pos = i;
          break;
        end
      end
      for (i = pos; i + 1 < fill; i++) ranked[i] = ranked[i+1];
      fill--;
    end

    // Shift the arrival line, newest at the head
    for (i = MAX_WINDOW - 1; i > 0; i--) arrivals[i] = arrivals[i-1];
    arrivals[0] = s;

    // Insert after any equal entries
    if (fill < MAX_WINDOW) begin
      pos = fill;
      while (pos > 0 && s < ranked[pos-1]) begin
        ranked[pos] = ranked[pos-1];
        pos--;
      end
      ranked[pos] = s;
      fill++;
    end

    med = ranked[(span-1)/2];
    return fill == span;
  endfunction

  // Follow every transfer: register writes, results, then new samples
  always @(posedge clk_i or negedge rst_ni) begin : track
    sample_t want;
    sample_t got;
    if (!rst_ni) begin
      window_reg       = cfg_t'(WINDOW_RESET);
      fill             = 0;
      expected_medians.delete();
      mismatch_count_o = 0;
      backlog_o        = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        window_reg = cfg_i.window_size;
        fill       = 0;
      end

      if (med_i.valid && med_i.ready) begin
        if (expected_medians.size() == 0) begin
          $error("median: unexpected result, actual %0d", med_i.median);
          mismatch_count_o++;
        end else begin
          want = expected_medians.pop_front();
          if (med_i.median !== want) begin
            $error("median: expected %0d, actual %0d", want, med_i.median);
            mismatch_count_o++;
          end
        end
      end

      if (samp_i.valid && samp_i.ready) begin
        if (advance_window(samp_i.sample, got)) expected_medians.push_back(got);
      end

      backlog_o = expected_medians.size();
    end
  end

endmodule

/* tb/sliding_window_median_tb.sv */
`timescale 1ns / 100ps

module sliding_window_median_tb;
  import swm_pkg::*;

  localparam int unsigned ITEM_TARGET  = 650;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned STALL_LIMIT  = 2000;

  localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam sample_t SAMPLE_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_STEADY} rx_mode_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned mismatch_count;
  int unsigned median_backlog;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned idle_cycles = 0;
  sample_t     last_sample;

  swm_sample_if samp ();
  swm_median_if med ();
  swm_cfg_if    cfg ();

  sliding_window_median i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .samp_i (samp),
    .med_o  (med),
    .cfg_i  (cfg)
  );

  swm_median_check i_median_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .samp_i           (samp),
    .med_i            (med),
    .cfg_i            (cfg),
    .mismatch_count_o (mismatch_count),
    .backlog_o        (median_backlog)
  );

  always #1 clk_i = ~clk_i;

  // Abort when no channel has moved a transfer for too long
  always @(posedge clk_i) begin
    if ((samp.valid && samp.ready) || (med.valid && med.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** sliding_window_median: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mix of wide random values, a narrow band with many ties, extremes and repeats
  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: s = sample_t'($urandom);
      5, 6, 7:       s = sample_t'(int'($urandom_range(0, 8)) - 4);
      8: begin
        case ($urandom_range(0, 3))
          0:       s = SAMPLE_MAX;
          1:       s = SAMPLE_MIN;
          2:       s = '0;
          default: s = '1;
        endcase
      end
      default:       s = last_sample;
    endcase
    last_sample = s;
    return s;
  endfunction

  // Offer one sample in bursts with random gaps; enter and leave at a falling edge
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        samp.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    samp.valid  <= 1'b1;
    samp.sample <= s;
    do @(posedge clk_i); while (!samp.ready);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic write_window(input cfg_t w);
    cfg.window_size <= w;
    cfg.valid       <= 1'b1;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // Hold the input until every expected median is back and the pipe is empty
  task automatic settle();
    samp.valid <= 1'b0;
    while (median_backlog != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Result channel stalls: random segments, plus one long hold on request
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned seg_left;
    bit          hold_done;
    int unsigned tick;
    med.ready = 1'b0;
    seg_left  = 0;
    hold_done = 1'b0;
    tick      = 0;
    mode      = RX_FREE;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_req && !hold_done) begin
        med.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 64);
          mode     = rx_mode_e'($urandom_range(0, 3));
        end
        seg_left--;
        case (mode)
          RX_FREE:   med.ready <= 1'b1;
          RX_COIN:   med.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: med.ready <= ($urandom_range(0, 4) == 0);
          default:   med.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    cfg_t        win;
    int unsigned span;
    int unsigned phase;
    samp.valid      = 1'b0;
    samp.sample     = '0;
    cfg.valid       = 1'b0;
    cfg.window_size = '0;
    burst_left      = 0;
    items_sent      = 0;
    last_sample     = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset window of 64: extremes first, then fill well past the window
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample('1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(32'sd1);
    send_sample(-32'sd2);
    repeat (90) send_sample(rand_sample());
    settle();

    // Window of one passes samples straight through
    write_window(cfg_t'(1));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample('1);
    settle();

    // Window of zero acts as one
    write_window(cfg_t'(0));
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    settle();

    // Even window takes the lower middle value
    write_window(cfg_t'(2));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    settle();

    // Equal samples leaving the window
    write_window(cfg_t'(3));
    send_sample(32'sd7);
    send_sample(32'sd7);
    send_sample(-32'sd3);
    send_sample(32'sd7);
    send_sample(-32'sd3);
    settle();

    // Back up the result path while samples keep coming
    write_window(cfg_t'(1));
    hold_req <= 1'b1;
    repeat (60) send_sample(rand_sample());
    settle();

    // Random phases: saturating and edge sizes first, then mostly small windows
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       win = cfg_t'(127);
        1:       win = cfg_t'(65);
        2:       win = cfg_t'(64);
        3:       win = cfg_t'(63);
        4:       win = cfg_t'(2);
        default: win = ($urandom_range(0, 3) == 0) ? cfg_t'($urandom_range(0, 127))
                                                   : cfg_t'($urandom_range(1, 12));
      endcase
      span = (win == 0) ? 1 : (win > MAX_WINDOW) ? MAX_WINDOW : win;
      write_window(win);
      repeat (span + $urandom_range(10, 40)) send_sample(rand_sample());
      settle();
      phase++;
    end

    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && median_backlog == 0) begin
      $display("** sliding_window_median: PASSED **");
    end else begin
      $display("** sliding_window_median: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/swm_pkg.sv
hw/rtl/swm_if.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_prefix.sv
hw/rtl/swm_outq.sv
hw/rtl/sliding_window_median.sv
hw/rtl/swm_checker.sv
tb/swm_median_check.sv
tb/sliding_window_median_tb.sv
